// File: rtl/core/rhsv_pkg.sv
// Shared widths, constants and types for the RGB to HSV conversion core.
`default_nettype none

package rhsv_pkg;

    localparam int CH_W     = 8;
    localparam int HUE_W    = 15;
    localparam int DIV_QW   = 12;
    localparam int NUM_W    = 20;

    localparam int HUE_SECTOR = 3840;
    localparam int HUE_CIRCLE = 23040;

    localparam logic [HUE_W-1:0] HUE_BASE_RED   = HUE_W'(0);
    localparam logic [HUE_W-1:0] HUE_BASE_GREEN = HUE_W'(2 * HUE_SECTOR);
    localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = HUE_W'(4 * HUE_SECTOR);
    localparam logic [HUE_W:0]   HUE_WRAP       = (HUE_W + 1)'(HUE_CIRCLE);

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        logic               achrom;
        logic               neg;
        sector_t            sector;
        logic [CH_W-1:0]    hi;
    } side_t;

endpackage

`default_nettype wire

// File: rtl/core/rhsv_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module rhsv_div
    import rhsv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [CH_W-1:0]   den,
    output logic [DIV_QW-1:0]      quo,
    output logic                   rem_nz
);

    logic [NUM_W-1:0]  rem_reg  [DIV_QW];
    logic [CH_W-1:0]   den_reg  [DIV_QW];
    logic [DIV_QW-1:0] quo_reg  [DIV_QW];
    logic [NUM_W-1:0]  rem_next [DIV_QW];
    logic [CH_W-1:0]   den_next [DIV_QW];
    logic [DIV_QW-1:0] quo_next [DIV_QW];

    always_comb begin
        logic [NUM_W-1:0]  rin;
        logic [CH_W-1:0]   din;
        logic [DIV_QW-1:0] qin;
        logic [NUM_W-1:0]  trial;
        for (int s = 0; s < DIV_QW; s++) begin
            if (s == 0) begin
                rin = num;
                din = den;
                qin = '0;
            end else begin
                rin = rem_reg[s-1];
                din = den_reg[s-1];
                qin = quo_reg[s-1];
            end
            trial = NUM_W'(din) << (DIV_QW - 1 - s);
            den_next[s] = din;
            if (rin >= trial) begin
                rem_next[s] = rin - trial;
                quo_next[s] = qin | (DIV_QW'(1) << (DIV_QW - 1 - s));
            end else begin
                rem_next[s] = rin;
                quo_next[s] = qin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DIV_QW; s++) begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo    = quo_reg[DIV_QW-1];
    assign rem_nz = |rem_reg[DIV_QW-1];

endmodule

`default_nettype wire

// File: rtl/core/rgb_to_hsv_converter_core.sv
// Top level of the RGB to HSV conversion core.
// Throughput: one pixel per cycle unless the output stalls; a stage for channel sort,
// twelve divider stages (one quotient bit each, hue and saturation side by side),
// one hue stage.
// The whole pipe holds while the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
`default_nettype none

module rgb_to_hsv_converter_core
    import rhsv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CH_W-1:0]   s_red,
    input  wire logic [CH_W-1:0]   s_green,
    input  wire logic [CH_W-1:0]   s_blue,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [HUE_W-1:0]       m_hue,
    output logic [CH_W-1:0]        m_saturation,
    output logic [CH_W-1:0]        m_brightness
);

    logic              adv;

    side_t             side1_next;
    logic [CH_W-1:0]   diff1_next;
    logic [CH_W-1:0]   delta1_next;
    logic [CH_W-1:0]   lo1;
    logic [CH_W-1:0]   plus1;
    logic [CH_W-1:0]   minus1;

    logic              vld1_reg;
    side_t             side1_reg;
    logic [CH_W-1:0]   diff1_reg;
    logic [CH_W-1:0]   delta1_reg;

    logic              vld_reg  [DIV_QW];
    side_t             side_reg [DIV_QW];

    logic [NUM_W-1:0]  hue_num;
    logic [NUM_W-1:0]  sat_num;
    logic [DIV_QW-1:0] hue_quo;
    logic              hue_rem_nz;
    logic [DIV_QW-1:0] sat_quo;
    logic              sat_rem_nz;

    side_t             side_out;
    logic [HUE_W-1:0]  base;
    logic [HUE_W:0]    hue_sum;
    logic [HUE_W:0]    qq;
    logic [HUE_W-1:0]  hue_next;
    logic [CH_W-1:0]   sat_next;

    logic              m_valid_reg;
    logic [HUE_W-1:0]  m_hue_reg;
    logic [CH_W-1:0]   m_sat_reg;
    logic [CH_W-1:0]   m_bright_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        lo1 = s_red;
        if (s_green < lo1) begin
            lo1 = s_green;
        end
        if (s_blue < lo1) begin
            lo1 = s_blue;
        end
        priority if (s_red >= s_green && s_red >= s_blue) begin
            side1_next.sector = SECT_RED;
            side1_next.hi     = s_red;
            plus1             = s_green;
            minus1            = s_blue;
        end else if (s_green >= s_blue) begin
            side1_next.sector = SECT_GREEN;
            side1_next.hi     = s_green;
            plus1             = s_blue;
            minus1            = s_red;
        end else begin
            side1_next.sector = SECT_BLUE;
            side1_next.hi     = s_blue;
            plus1             = s_red;
            minus1            = s_green;
        end
        side1_next.achrom = (s_red == s_green) && (s_green == s_blue);
        side1_next.neg    = plus1 < minus1;
        diff1_next        = side1_next.neg ? (minus1 - plus1) : (plus1 - minus1);
        delta1_next       = side1_next.hi - lo1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (adv) begin
            vld1_reg <= s_valid;
        end
        if (adv) begin
            side1_reg  <= side1_next;
            diff1_reg  <= diff1_next;
            delta1_reg <= delta1_next;
        end
    end

    assign hue_num = (NUM_W'(diff1_reg) << 12) - (NUM_W'(diff1_reg) << 8);
    assign sat_num = (NUM_W'(delta1_reg) << 8) - NUM_W'(delta1_reg);

    rhsv_div u_hue_div (
        .aclk   (aclk),
        .en     (adv),
        .num    (hue_num),
        .den    (delta1_reg),
        .quo    (hue_quo),
        .rem_nz (hue_rem_nz)
    );

    rhsv_div u_sat_div (
        .aclk   (aclk),
        .en     (adv),
        .num    (sat_num),
        .den    (side1_reg.hi),
        .quo    (sat_quo),
        .rem_nz (sat_rem_nz)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < DIV_QW; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= vld1_reg;
            for (int s = 1; s < DIV_QW; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
        if (adv) begin
            side_reg[0] <= side1_reg;
            for (int s = 1; s < DIV_QW; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign side_out = side_reg[DIV_QW-1];

    always_comb begin
        unique case (side_out.sector)
            SECT_RED:   base = HUE_BASE_RED;
            SECT_GREEN: base = HUE_BASE_GREEN;
            SECT_BLUE:  base = HUE_BASE_BLUE;
            default:    base = HUE_BASE_RED;
        endcase
        qq = (HUE_W + 1)'(hue_quo) + (HUE_W + 1)'(hue_rem_nz);
        if (!side_out.neg) begin
            hue_sum = (HUE_W + 1)'(base) + (HUE_W + 1)'(hue_quo);
        end else if ((HUE_W + 1)'(base) >= qq) begin
            hue_sum = (HUE_W + 1)'(base) - qq;
        end else begin
            hue_sum = (HUE_W + 1)'(base) + HUE_WRAP - qq;
        end
        if (hue_sum >= HUE_WRAP) begin
            hue_sum = hue_sum - HUE_WRAP;
        end
        if (side_out.achrom) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = hue_sum[HUE_W-1:0];
            sat_next = sat_quo[CH_W-1:0] | {CH_W{sat_rem_nz & 1'b0}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[DIV_QW-1];
        end
        if (adv) begin
            m_hue_reg    <= hue_next;
            m_sat_reg    <= sat_next;
            m_bright_reg <= side_out.hi;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hue        = m_hue_reg;
    assign m_saturation = m_sat_reg;
    assign m_brightness = m_bright_reg;

endmodule

`default_nettype wire

// File: rtl/core/rhsv_checker.sv
// Port-level checks for the RGB to HSV conversion core, bound to the top level.
`default_nettype none

module rhsv_checker
    import rhsv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [CH_W-1:0]   s_red,
    input  wire logic [CH_W-1:0]   s_green,
    input  wire logic [CH_W-1:0]   s_blue,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [HUE_W-1:0]  m_hue,
    input  wire logic [CH_W-1:0]   m_saturation,
    input  wire logic [CH_W-1:0]   m_brightness
);

    logic in_beat;

    assign in_beat = s_valid && s_ready && (|{s_red, s_green, s_blue} || 1'b1);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hue) && $stable(m_saturation))
        else $error("stalled result beat changed or dropped");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hue < HUE_W'(HUE_CIRCLE)))
        else $error("hue out of range");

    a_gray_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_saturation == '0 || m_brightness == '0) |->
            (m_hue == '0) && (m_saturation == '0))
        else $error("gray pixel with nonzero hue");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !in_beat)
        else $error("input beat taken while pipe is stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rgb_to_hsv_converter_core rhsv_checker u_rhsv_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_red        (s_red),
    .s_green      (s_green),
    .s_blue       (s_blue),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hue        (m_hue),
    .m_saturation (m_saturation),
    .m_brightness (m_brightness)
);

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the RGB to HSV conversion core.
`default_nettype none

module testbench
    import rhsv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 1850;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        int unsigned     gap;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [CH_W-1:0]  s_red = '0;
    logic [CH_W-1:0]  s_green = '0;
    logic [CH_W-1:0]  s_blue = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [HUE_W-1:0] m_hue;
    logic [CH_W-1:0]  m_saturation;
    logic [CH_W-1:0]  m_brightness;

    pixel_t      pixel_queue[$];
    hsv_t        hsv_expected[$];
    pixel_t      staged;
    logic        have_staged = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned pixels_in = 0;
    int unsigned gray_in = 0;
    int unsigned wrapped_in = 0;
    int unsigned results_out = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    hsv_t        want;

    rgb_to_hsv_converter_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_brightness (m_brightness)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic hsv_t hsv_of(input logic [CH_W-1:0] r, g, b);
        hsv_t            res;
        sector_t         sect;
        logic [CH_W-1:0] hi, lo, plus, minus;
        int unsigned     delta, base, q, h;
        if (r == g && g == b) begin
            res.hue        = '0;
            res.saturation = '0;
            res.brightness = r;
            return res;
        end
        lo = (g < r) ? g : r;
        if (b < lo) lo = b;
        if (r >= g && r >= b) begin
            sect = SECT_RED;   hi = r; plus = g; minus = b;
        end else if (g >= b) begin
            sect = SECT_GREEN; hi = g; plus = b; minus = r;
        end else begin
            sect = SECT_BLUE;  hi = b; plus = r; minus = g;
        end
        case (sect)
            SECT_RED:   base = HUE_BASE_RED;
            SECT_GREEN: base = HUE_BASE_GREEN;
            default:    base = HUE_BASE_BLUE;
        endcase
        delta = hi - lo;
        if (plus >= minus) begin
            h = base + (HUE_SECTOR * (plus - minus)) / delta;
        end else begin
            // floor of a negative fraction: step down by the ceiling of its magnitude
            q = (HUE_SECTOR * (minus - plus) + delta - 1) / delta;
            h = (base >= q) ? base - q : base + HUE_CIRCLE - q;
        end
        if (h >= HUE_CIRCLE) h = h - HUE_CIRCLE;
        res.hue        = h[HUE_W-1:0];
        res.saturation = CH_W'((255 * delta) / hi);
        res.brightness = hi;
        return res;
    endfunction

    task automatic add_pixel(input int unsigned r, g, b, gap);
        pixel_t p;
        p.red   = r[CH_W-1:0];
        p.green = g[CH_W-1:0];
        p.blue  = b[CH_W-1:0];
        p.gap   = gap;
        pixel_queue.push_back(p);
    endtask

    // Driver: one beat per pixel, with the drawn gap ahead of it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                hsv_expected.push_back(hsv_of(s_red, s_green, s_blue));
                pixels_in++;
                if (s_red == s_green && s_green == s_blue)
                    gray_in++;
                else if (s_red >= s_green && s_red >= s_blue && s_green < s_blue)
                    wrapped_in++;
            end
            if (!(s_valid && !s_ready)) begin
                if (!have_staged && pixel_queue.size() != 0) begin
                    staged      = pixel_queue.pop_front();
                    have_staged = 1'b1;
                    gap_left    = staged.gap;
                end
                if (have_staged && gap_left == 0) begin
                    s_valid     <= 1'b1;
                    s_red       <= staged.red;
                    s_green     <= staged.green;
                    s_blue      <= staged.blue;
                    have_staged = 1'b0;
                end else begin
                    s_valid <= 1'b0;
                    if (have_staged) gap_left--;
                end
            end
        end
    end

    // Monitor: check each result beat, then stall for a drawn number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = $urandom_range(0, 11);
        end else begin
            if (m_valid && m_ready) begin
                results_out++;
                if (hsv_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result hue=%0d saturation=%0d brightness=%0d",
                             $time, m_hue, m_saturation, m_brightness);
                end else begin
                    want = hsv_expected.pop_front();
                    if (m_hue !== want.hue) begin
                        mismatches++;
                        $display("%0t: hue expected %0d, actual %0d",
                                 $time, want.hue, m_hue);
                    end
                    if (m_saturation !== want.saturation) begin
                        mismatches++;
                        $display("%0t: saturation expected %0d, actual %0d",
                                 $time, want.saturation, m_saturation);
                    end
                    if (m_brightness !== want.brightness) begin
                        mismatches++;
                        $display("%0t: brightness expected %0d, actual %0d",
                                 $time, want.brightness, m_brightness);
                    end
                end
                stall_left = ((results_out / 150) % 4 == 2) ? 0 : $urandom_range(0, 11);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, hsv_expected.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned kind, base, v, x, gap;
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 0);
        add_pixel(128, 128, 128, 2);
        add_pixel(255, 0, 0, 0);
        add_pixel(0, 255, 0, 0);
        add_pixel(0, 0, 255, 1);
        add_pixel(255, 255, 0, 0);
        add_pixel(255, 0, 255, 0);
        add_pixel(0, 255, 255, 0);
        add_pixel(255, 0, 1, 3);
        add_pixel(255, 1, 0, 0);
        add_pixel(1, 0, 0, 0);
        add_pixel(0, 0, 1, 0);
        add_pixel(1, 1, 0, 5);
        add_pixel(254, 255, 255, 0);
        add_pixel(255, 254, 0, 0);
        add_pixel(1, 0, 255, 0);
        add_pixel(200, 100, 150, 11);
        add_pixel(10, 200, 30, 0);
        add_pixel(30, 20, 250, 0);
        add_pixel(100, 50, 50, 0);
        add_pixel(50, 100, 100, 0);
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), 0);
            end else if (kind < 60) begin
                v = $urandom_range(0, 255);
                add_pixel(v, v, v, 0);
            end else if (kind < 78) begin
                v = $urandom_range(0, 255);
                x = $urandom_range(0, 255);
                case ($urandom_range(0, 2))
                    0:       add_pixel(v, v, x, 0);
                    1:       add_pixel(v, x, v, 0);
                    default: add_pixel(x, v, v, 0);
                endcase
            end else begin
                base = $urandom_range(0, 252);
                add_pixel(base + $urandom_range(0, 3), base + $urandom_range(0, 3),
                          base + $urandom_range(0, 3), 0);
            end
            gap = ((i / 125) % 4 == 1) ? 0 : $urandom_range(0, 11);
            pixel_queue[pixel_queue.size() - 1].gap = gap;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pixel_queue.size() != 0 || have_staged || s_valid || hsv_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d pixels (%0d gray, %0d with hue wrapped below 360 degrees),",
                 pixels_in, gray_in, wrapped_in);
        $display("checked %0d results under random input gaps and output stalls.", results_out);
        if (mismatches == 0 && hsv_expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/rhsv_pkg.sv
rtl/core/rhsv_div.sv
rtl/core/rgb_to_hsv_converter_core.sv
rtl/core/rhsv_checker.sv
bench/testbench.sv
